### src/ncrm_pkg.sv
package ncrm_pkg;

  localparam int RULE_SLOTS = 64;
  localparam int SLOT_W     = $clog2(RULE_SLOTS);
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [2:0] OC_EXACT    = 3'd0;
  localparam logic [2:0] OC_OWN      = 3'd1;
  localparam logic [2:0] OC_NONE     = 3'd2;
  localparam logic [2:0] OC_NEAR_IN  = 3'd3;
  localparam logic [2:0] OC_NEAR_OUT = 3'd4;
  localparam logic [2:0] OC_WRITE    = 3'd5;

  localparam logic [1:0] CFG_RADIUS    = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_COUNT     = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [5:0] rule_index;
    logic       rule_enabled;
    logic [7:0] src_r;
    logic [7:0] src_g;
    logic [7:0] src_b;
    logic [7:0] dst_r;
    logic [7:0] dst_g;
    logic [7:0] dst_b;
    logic [7:0] query_r;
    logic [7:0] query_g;
    logic [7:0] query_b;
  } in_t;

  typedef struct packed {
    logic       mapped;
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic [2:0] outcome;
  } out_t;

endpackage

### src/nearest_color_rule_matcher.sv
// Color rule table with nearest-match lookup. A rule write beat answers with a "write done"
// result. A lookup reads the rules one per cycle from the single rule memory, starting at
// slot zero, and runs each through a three-stage distance pipeline; it scans the first
// rule_count slots, capped at 64, answers with no match and no scan when that count is zero,
// and ends early on an exact source match. The rule memory has no reset: only slots that were
// written may be scanned. Configuration registers take one write per cycle and must be
// written while the block is idle.
module nearest_color_rule_matcher (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ncrm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ncrm_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [17:0]    cfg_data_i
);
  import ncrm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_e;

  typedef struct packed {
    logic       en;
    logic [7:0] sr;
    logic [7:0] sg;
    logic [7:0] sb;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
  } rule_t;

  function automatic logic [15:0] sq8(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  rule_t rule_mem [RULE_SLOTS];

  state_e          state_q;
  logic [17:0]     radius_q;
  logic [17:0]     tol_q;
  logic [6:0]      count_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] n_d;
  logic [SLOT_W-1:0] addr_q;
  logic            iss_q;
  logic [23:0]     query_q;
  rule_t           rd_q;
  logic            v1_q;
  logic            last1_q;
  logic            v2_q;
  logic            last2_q;
  logic            en2_q;
  logic [23:0]     dst2_q;
  logic [2:0][15:0] sq_src_q;
  logic [2:0][15:0] sq_dst_q;
  logic            found_q;
  logic            own_q;
  logic [17:0]     best_q;
  logic [23:0]     best_dst_q;
  out_t            out_q;
  logic            out_valid_q;

  logic            in_acc;
  logic            wr_en;
  logic            is_last;
  logic [17:0]     dist_s;
  logic [17:0]     dist_d;
  logic            hit;
  logic            exact;
  logic            better;
  logic            own_hit;
  logic            fin_mapped;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !(state_q == ST_IDLE && (!out_valid_q || !out_stall_i));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wr_en       = in_acc && in_data_i.req_type == REQ_WRITE &&
                       int'(in_data_i.rule_index) < RULE_SLOTS;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (int'(count_q) > RULE_SLOTS) begin
      n_d = CNT_W'(RULE_SLOTS);
    end else begin
      n_d = CNT_W'(count_q);
    end
  end

  assign is_last = CNT_W'(addr_q) == n_q - CNT_W'(1);

  assign dist_s     = 18'(sq_src_q[0]) + 18'(sq_src_q[1]) + 18'(sq_src_q[2]);
  assign dist_d     = 18'(sq_dst_q[0]) + 18'(sq_dst_q[1]) + 18'(sq_dst_q[2]);
  assign hit        = v2_q && en2_q;
  assign exact      = hit && dist_s == 18'd0;
  assign better     = hit && (!found_q || dist_s < best_q);
  assign own_hit    = hit && dist_d <= tol_q;
  assign fin_mapped = best_q <= radius_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rule_mem[SLOT_W'(in_data_i.rule_index)] <= '{
        en: in_data_i.rule_enabled,
        sr: in_data_i.src_r, sg: in_data_i.src_g, sb: in_data_i.src_b,
        dr: in_data_i.dst_r, dg: in_data_i.dst_g, db: in_data_i.dst_b};
    end
    rd_q <= rule_mem[addr_q];
  end

  // distance stage: squares of the per-channel differences
  always_ff @(posedge clk_i) begin
    en2_q       <= rd_q.en;
    dst2_q      <= {rd_q.dr, rd_q.dg, rd_q.db};
    sq_src_q[0] <= sq8(query_q[23:16], rd_q.sr);
    sq_src_q[1] <= sq8(query_q[15:8], rd_q.sg);
    sq_src_q[2] <= sq8(query_q[7:0], rd_q.sb);
    sq_dst_q[0] <= sq8(query_q[23:16], rd_q.dr);
    sq_dst_q[1] <= sq8(query_q[15:8], rd_q.dg);
    sq_dst_q[2] <= sq8(query_q[7:0], rd_q.db);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= '0;
      tol_q       <= '0;
      count_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS:    radius_q <= cfg_data_i;
        CFG_TOLERANCE: tol_q    <= cfg_data_i;
        CFG_COUNT:     count_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      addr_q      <= '0;
      iss_q       <= 1'b0;
      query_q     <= '0;
      v1_q        <= 1'b0;
      last1_q     <= 1'b0;
      v2_q        <= 1'b0;
      last2_q     <= 1'b0;
      found_q     <= 1'b0;
      own_q       <= 1'b0;
      best_q      <= '0;
      best_dst_q  <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          v1_q <= 1'b0;
          v2_q <= 1'b0;
          if (in_acc) begin
            if (in_data_i.req_type == REQ_WRITE) begin
              out_q       <= '{mapped: 1'b0, out_r: 8'd0, out_g: 8'd0, out_b: 8'd0,
                               outcome: OC_WRITE};
              out_valid_q <= 1'b1;
            end else begin
              query_q <= {in_data_i.query_r, in_data_i.query_g, in_data_i.query_b};
              n_q     <= n_d;
              addr_q  <= '0;
              found_q <= 1'b0;
              own_q   <= 1'b0;
              if (n_d == '0) begin
                out_q       <= '{mapped: 1'b0, out_r: 8'd0, out_g: 8'd0, out_b: 8'd0,
                                 outcome: OC_NONE};
                out_valid_q <= 1'b1;
              end else begin
                iss_q   <= 1'b1;
                state_q <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          v1_q    <= iss_q;
          last1_q <= iss_q && is_last;
          if (iss_q) begin
            addr_q <= addr_q + SLOT_W'(1);
            if (is_last) begin
              iss_q <= 1'b0;
            end
          end
          v2_q    <= v1_q;
          last2_q <= last1_q;
          if (exact) begin
            out_q       <= '{mapped: 1'b1, out_r: dst2_q[23:16], out_g: dst2_q[15:8],
                             out_b: dst2_q[7:0], outcome: OC_EXACT};
            out_valid_q <= 1'b1;
            iss_q       <= 1'b0;
            v1_q        <= 1'b0;
            v2_q        <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            if (better) begin
              found_q    <= 1'b1;
              best_q     <= dist_s;
              best_dst_q <= dst2_q;
            end
            if (own_hit) begin
              own_q <= 1'b1;
            end
            if (v2_q && last2_q) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          v1_q <= 1'b0;
          v2_q <= 1'b0;
          if (own_q) begin
            out_q <= '{mapped: 1'b0, out_r: 8'd0, out_g: 8'd0, out_b: 8'd0,
                       outcome: OC_OWN};
          end else if (!found_q) begin
            out_q <= '{mapped: 1'b0, out_r: 8'd0, out_g: 8'd0, out_b: 8'd0,
                       outcome: OC_NONE};
          end else begin
            out_q <= '{mapped: fin_mapped, out_r: best_dst_q[23:16],
                       out_g: best_dst_q[15:8], out_b: best_dst_q[7:0],
                       outcome: fin_mapped ? OC_NEAR_IN : OC_NEAR_OUT};
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/ncrm_checker.sv
module ncrm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input ncrm_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ncrm_pkg::out_t out_data_o
);
  import ncrm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_write_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == REQ_WRITE |=>
      out_valid_o && out_data_o.outcome == OC_WRITE)
    else $error("rule write beat not answered next cycle");

  a_mapped_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mapped |->
      out_data_o.outcome == OC_EXACT || out_data_o.outcome == OC_NEAR_IN)
    else $error("mapped flag with a non-mapping outcome");

  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OC_OWN || out_data_o.outcome == OC_NONE ||
                    out_data_o.outcome == OC_WRITE) |->
      !out_data_o.mapped && out_data_o.out_r == 8'd0 && out_data_o.out_g == 8'd0 &&
      out_data_o.out_b == 8'd0)
    else $error("unmapped outcome carries a color");

endmodule

bind nearest_color_rule_matcher ncrm_checker u_ncrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### verif/nearest_color_rule_matcher_test.sv
`timescale 1ns / 1ps

module nearest_color_rule_matcher_test;
  import ncrm_pkg::*;

  localparam int unsigned RUN_LIMIT    = 2000000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned TAIL_CYCLES  = RULE_SLOTS + 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;
  localparam logic [17:0] REG_ONES     = 18'h3FFFF;
  localparam logic [17:0] DIST_MAX     = 18'd195075;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic       en;
    logic [7:0] sr;
    logic [7:0] sg;
    logic [7:0] sb;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
  } color_rule_t;

  typedef struct {
    row_kind_e   kind;
    in_t         item;
    logic [1:0]  reg_idx;
    logic [17:0] reg_val;
    bit          typed;
    out_t        want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [17:0] cfg_data_i;

  nearest_color_rule_matcher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  color_rule_t rule_mem [RULE_SLOTS];
  logic [17:0] radius_cfg;
  logic [17:0] tol_cfg;
  logic [6:0]  count_cfg;

  out_t        pending_colors [$];
  plan_row_t   plan_rows [$];
  int unsigned outcome_hits [6];
  int unsigned fail_count;
  int unsigned beats_out;
  int unsigned items_sent;
  int unsigned tick_count;
  int unsigned reg_writes;
  bit          sender_calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    tick_count <= tick_count + 1;
    if (tick_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", tick_count,
               pending_colors.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned color_dist2(logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
                                              logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
    int dr;
    int dg;
    int db;
    dr = int'(ar) - int'(br);
    dg = int'(ag) - int'(bg);
    db = int'(ab) - int'(bb);
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic out_t color_out(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [2:0] oc);
    out_t o;
    o.mapped  = m;
    o.out_r   = r;
    o.out_g   = g;
    o.out_b   = b;
    o.outcome = oc;
    return o;
  endfunction

  // updates the rule store on a write, scans it on a lookup
  function automatic out_t predict_color(in_t it);
    int unsigned span;
    int unsigned d;
    int unsigned best_d;
    int unsigned best_i;
    bit          found;
    bit          own;
    color_rule_t cr;
    if (it.req_type == REQ_WRITE) begin
      cr = '{en: it.rule_enabled, sr: it.src_r, sg: it.src_g, sb: it.src_b,
             dr: it.dst_r, dg: it.dst_g, db: it.dst_b};
      rule_mem[it.rule_index] = cr;
      return color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_WRITE);
    end
    span   = (count_cfg > RULE_SLOTS) ? RULE_SLOTS : count_cfg;
    found  = 1'b0;
    own    = 1'b0;
    best_d = 0;
    best_i = 0;
    for (int unsigned i = 0; i < span; i++) begin
      cr = rule_mem[i];
      if (!cr.en) continue;
      d = color_dist2(it.query_r, it.query_g, it.query_b, cr.sr, cr.sg, cr.sb);
      if (d == 0) return color_out(1'b1, cr.dr, cr.dg, cr.db, OC_EXACT);
      if (!found || d < best_d) begin
        found  = 1'b1;
        best_d = d;
        best_i = i;
      end
      if (!own && color_dist2(it.query_r, it.query_g, it.query_b, cr.dr, cr.dg, cr.db)
          <= tol_cfg) own = 1'b1;
    end
    if (own) return color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_OWN);
    if (!found) return color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_NONE);
    cr = rule_mem[best_i];
    if (best_d <= radius_cfg) return color_out(1'b1, cr.dr, cr.dg, cr.db, OC_NEAR_IN);
    return color_out(1'b0, cr.dr, cr.dg, cr.db, OC_NEAR_OUT);
  endfunction

  function automatic in_t noise_item();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return in_t'(bits[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t write_item(logic [5:0] slot, logic en, logic [7:0] sr, logic [7:0] sg,
                                     logic [7:0] sb, logic [7:0] dr, logic [7:0] dg,
                                     logic [7:0] db);
    in_t it;
    it              = noise_item();
    it.req_type     = REQ_WRITE;
    it.rule_index   = slot;
    it.rule_enabled = en;
    it.src_r        = sr;
    it.src_g        = sg;
    it.src_b        = sb;
    it.dst_r        = dr;
    it.dst_g        = dg;
    it.dst_b        = db;
    return it;
  endfunction

  function automatic in_t lookup_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_t it;
    it          = noise_item();
    it.req_type = REQ_LOOKUP;
    it.query_r  = r;
    it.query_g  = g;
    it.query_b  = b;
    return it;
  endfunction

  function automatic plan_row_t item_row(in_t it, bit typed, out_t want);
    plan_row_t row;
    row.kind    = ROW_ITEM;
    row.item    = it;
    row.reg_idx = CFG_RADIUS;
    row.reg_val = '0;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [17:0] val);
    plan_row_t row;
    row         = item_row('0, 1'b0, '0);
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic add_row(input plan_row_t row);
    plan_rows.insert(plan_rows.size(), row);
  endtask

  function automatic logic [7:0] palette();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'd64;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic in_t rand_write(logic [5:0] slot);
    return write_item(slot, $urandom_range(0, 99) < 85, palette(), palette(), palette(),
                      palette(), palette(), palette());
  endfunction

  function automatic in_t rand_lookup();
    color_rule_t cr;
    int unsigned pick;
    cr   = rule_mem[$urandom_range(0, RULE_SLOTS - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 30) return lookup_item(cr.sr, cr.sg, cr.sb);
    if (pick < 50) return lookup_item(jitter(cr.sr), jitter(cr.sg), jitter(cr.sb));
    if (pick < 65) return lookup_item(jitter(cr.dr), jitter(cr.dg), jitter(cr.db));
    return lookup_item(8'($urandom()), 8'($urandom()), 8'($urandom()));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [17:0] pick_radius(int unsigned phase);
    case (phase)
      0: return REG_ONES;
      1: return 18'd0;
      2: return DIST_MAX;
      default: begin
        case ($urandom_range(0, 5))
          0: return 18'd0;
          1: return DIST_MAX;
          2: return REG_ONES;
          3: return 18'($urandom_range(0, 262143));
          default: return 18'($urandom_range(0, 3000));
        endcase
      end
    endcase
  endfunction

  function automatic logic [17:0] pick_tol(int unsigned phase);
    if (phase < 3) return 18'($urandom_range(0, 20));
    case ($urandom_range(0, 9))
      0, 1, 2: return 18'd0;
      3: return (($urandom_range(0, 1) != 0) ? DIST_MAX : REG_ONES);
      4: return 18'($urandom_range(0, 262143));
      default: return 18'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic logic [6:0] pick_count(int unsigned phase);
    case (phase)
      0: return 7'd127;
      1: return 7'd65;
      2: return 7'd64;
      default: begin
        case ($urandom_range(0, 7))
          0: return 7'd0;
          1: return 7'd1;
          2: return 7'd64;
          3: return 7'($urandom_range(65, 127));
          default: return 7'($urandom_range(1, 64));
        endcase
      end
    endcase
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic offer_item(input in_t it, input bit typed, input out_t want);
    out_t        got;
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_color(it);
    if (typed) got = want;
    pending_colors.insert(pending_colors.size(), got);
    outcome_hits[got.outcome]++;
    items_sent++;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [17:0] val);
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_RADIUS:    radius_cfg = val;
      CFG_TOLERANCE: tol_cfg    = val;
      CFG_COUNT:     count_cfg  = val[6:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (pending_colors.size() == 0) begin
        note_fail($sformatf("unexpected result beat: m=%0b rgb=%02h%02h%02h oc=%0d",
                            out_data_o.mapped, out_data_o.out_r, out_data_o.out_g,
                            out_data_o.out_b, out_data_o.outcome));
      end else begin
        want = pending_colors.pop_front();
        if (out_data_o.mapped !== want.mapped || out_data_o.out_r !== want.out_r ||
            out_data_o.out_g !== want.out_g || out_data_o.out_b !== want.out_b ||
            out_data_o.outcome !== want.outcome) begin
          note_fail($sformatf({"result %0d: want m=%0b rgb=%02h%02h%02h oc=%0d,",
                               " got m=%0b rgb=%02h%02h%02h oc=%0d"}, beats_out,
                              want.mapped, want.out_r, want.out_g, want.out_b, want.outcome,
                              out_data_o.mapped, out_data_o.out_r, out_data_o.out_g,
                              out_data_o.out_b, out_data_o.outcome));
        end
      end
    end
  end

  // receiver: random stall bursts, plus two long hold-offs so the block backs up
  initial begin
    int unsigned hold_marks [2];
    int unsigned hold_i;
    int unsigned r;
    int unsigned len;
    logic        s;
    hold_marks  = '{300, 1100};
    hold_i      = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_i < 2 && beats_out >= hold_marks[hold_i]) begin
        hold_i++;
        s   = 1'b1;
        len = 600;
      end else if (r < 5) begin
        s   = 1'b0;
        len = $urandom_range(100, 200);
      end else if (r < 50) begin
        s   = 1'b0;
        len = $urandom_range(1, 30);
      end else if (r < 92) begin
        s   = 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        s   = 1'b1;
        len = $urandom_range(10, 60);
      end
      out_stall_i <= s;
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned phase;
    int unsigned len;
    in_t         it;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_RADIUS;
    cfg_data_i  <= '0;
    tick_count  = 0;
    fail_count  = 0;
    beats_out   = 0;
    items_sent  = 0;
    reg_writes  = 0;
    sender_calm = 1'b0;
    radius_cfg  = '0;
    tol_cfg     = '0;
    count_cfg   = '0;
    foreach (rule_mem[i]) rule_mem[i] = '0;
    foreach (outcome_hits[i]) outcome_hits[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    add_row(item_row(lookup_item(8'd10, 8'd20, 8'd30), 1'b1,
                     color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_NONE)));
    add_row(item_row(write_item(6'd0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0),
                     1'b1, color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_WRITE)));
    add_row(item_row(write_item(6'd1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255,
                                8'd0), 1'b1,
                     color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_WRITE)));
    add_row(item_row(write_item(6'd2, 1'b0, 8'd100, 8'd100, 8'd100, 8'd1, 8'd2,
                                8'd3), 1'b0, '0));
    add_row(item_row(write_item(6'd3, 1'b1, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0,
                                8'd255), 1'b0, '0));
    add_row(reg_row(CFG_COUNT, 18'd4));
    add_row(reg_row(CFG_SPARE, REG_ONES));
    add_row(item_row(lookup_item(8'd0, 8'd0, 8'd0), 1'b1,
                     color_out(1'b1, 8'd255, 8'd0, 8'd0, OC_EXACT)));
    add_row(item_row(lookup_item(8'd255, 8'd255, 8'd255), 1'b1,
                     color_out(1'b1, 8'd0, 8'd255, 8'd0, OC_EXACT)));
    add_row(item_row(lookup_item(8'd100, 8'd100, 8'd100), 1'b0, '0));
    add_row(item_row(lookup_item(8'd255, 8'd0, 8'd0), 1'b1,
                     color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_OWN)));
    add_row(reg_row(CFG_RADIUS, DIST_MAX));
    add_row(item_row(lookup_item(8'd100, 8'd100, 8'd100), 1'b0, '0));
    add_row(item_row(lookup_item(8'd200, 8'd10, 8'd90), 1'b0, '0));
    add_row(reg_row(CFG_TOLERANCE, REG_ONES));
    add_row(item_row(lookup_item(8'd10, 8'd20, 8'd30), 1'b0, '0));
    add_row(reg_row(CFG_TOLERANCE, 18'd0));
    add_row(reg_row(CFG_RADIUS, REG_ONES));
    add_row(item_row(lookup_item(8'd1, 8'd254, 8'd7), 1'b0, '0));
    add_row(item_row(write_item(6'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
                     1'b1, color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_WRITE)));
    add_row(item_row(write_item(6'd1, 1'b0, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9),
                     1'b0, '0));
    add_row(item_row(write_item(6'd3, 1'b0, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7),
                     1'b0, '0));
    add_row(item_row(lookup_item(8'd9, 8'd9, 8'd9), 1'b1,
                     color_out(1'b0, 8'd0, 8'd0, 8'd0, OC_NONE)));

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_CFG) begin
        set_reg(plan_rows[i].reg_idx, plan_rows[i].reg_val);
      end else begin
        offer_item(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    // fill every slot before any scan can reach past slot three
    rand_items = 0;
    for (int unsigned s = 0; s < RULE_SLOTS; s++) begin
      offer_item(rand_write(6'(s)), 1'b0, '0);
      rand_items++;
    end

    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      set_reg(CFG_RADIUS, pick_radius(phase));
      set_reg(CFG_TOLERANCE, pick_tol(phase));
      set_reg(CFG_COUNT, 18'(pick_count(phase)));
      sender_calm = ($urandom_range(0, 4) == 0);
      len = $urandom_range(60, 140);
      repeat (len) begin
        if ($urandom_range(0, 99) < 25) it = rand_write(6'($urandom_range(0, RULE_SLOTS - 1)));
        else it = rand_lookup();
        offer_item(it, 1'b0, '0);
        rand_items++;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_colors.size() != 0) note_fail("results still outstanding at end of run");

    $display("covered %0d items over %0d phases, %0d register writes, %0d failures",
             items_sent, phase, reg_writes, fail_count);
    $display("writes %0d, exact %0d, own %0d, none %0d, near-in %0d, near-out %0d",
             outcome_hits[OC_WRITE], outcome_hits[OC_EXACT], outcome_hits[OC_OWN],
             outcome_hits[OC_NONE], outcome_hits[OC_NEAR_IN], outcome_hits[OC_NEAR_OUT]);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
